// ===== rtl/core/tpwe_pkg.sv =====
// ----------------------------------------------------------------------------
// tpwe_pkg: shared types and constants of the tape pulse width encoder
// Sequence kinds, command and register codes, positions in a byte or
// checksum sequence, and the sequencer state that crosses module boundaries.
// ----------------------------------------------------------------------------
package tpwe_pkg;

	localparam int CMD_W   = 3;
	localparam int COUNT_W = 16;
	localparam int DATA_W  = 16;
	localparam int ONES_W  = 4;
	localparam int TOTAL_W = 32;
	localparam int POS_W   = 5;
	localparam int REG_W   = 3;

	// Command codes of an input item
	localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
	localparam logic [CMD_W-1:0] CMD_GAP  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MARK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_BYTE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CSUM = 3'd4;

	// Configuration register indexes
	localparam logic [REG_W-1:0] REG_LONG_LOW   = 3'd0;
	localparam logic [REG_W-1:0] REG_LONG_HIGH  = 3'd1;
	localparam logic [REG_W-1:0] REG_SHORT_LOW  = 3'd2;
	localparam logic [REG_W-1:0] REG_SHORT_HIGH = 3'd3;
	localparam logic [REG_W-1:0] REG_INVERT     = 3'd4;

	// Tape mark stages: long run, short run, closing pair
	localparam logic [1:0] MARK_LONG_RUN  = 2'd0;
	localparam logic [1:0] MARK_SHORT_RUN = 2'd1;
	localparam logic [1:0] MARK_CLOSE     = 2'd2;

	// Pulse positions within byte and checksum sequences
	localparam logic [POS_W-1:0] BYTE_DATA_END = 5'd8;   // stop pulse position
	localparam logic [POS_W-1:0] BYTE_END      = 5'd9;
	localparam logic [POS_W-1:0] CSUM_LO_START = 5'd9;
	localparam logic [POS_W-1:0] CSUM_LO_LAST  = 5'd16;
	localparam logic [POS_W-1:0] CSUM_END      = 5'd19;

	typedef enum logic [2:0] {
		KIND_IDLE = 3'd0,
		KIND_GAP  = 3'd1,
		KIND_MARK = 3'd2,
		KIND_BYTE = 3'd3,
		KIND_CSUM = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [1:0]         mark_stage;
		logic               pulse_long;
		logic [COUNT_W-1:0] pulses_left;
		logic [DATA_W-1:0]  bit_shift;
		logic [POS_W-1:0]   bit_index;
	} seq_t;

	typedef struct packed {
		logic done;
		seq_t nxt;
	} pulse_t;

	// A phase width of zero counts as one sample
	function automatic logic [COUNT_W-1:0] width_of(input logic [COUNT_W-1:0] v);
		width_of = (v == '0) ? COUNT_W'(1) : v;
	endfunction

	function automatic logic [ONES_W-1:0] ones8(input logic [7:0] b);
		logic [ONES_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			acc = acc + ONES_W'(b[i]);
		end
		ones8 = acc;
	endfunction

endpackage

// ===== rtl/core/tpwe_if.sv =====
// ----------------------------------------------------------------------------
// tpwe_if: channel interfaces of the tape pulse width encoder
// Command channel, sample result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface tpwe_req_if;
	logic                         valid;
	logic                         ready;
	logic [tpwe_pkg::CMD_W-1:0]   command;
	logic [tpwe_pkg::COUNT_W-1:0] repeat_count;
	logic [tpwe_pkg::DATA_W-1:0]  payload;

	modport source(output valid, command, repeat_count, payload, input ready);
	modport sink(input valid, command, repeat_count, payload, output ready);
endinterface

interface tpwe_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         sample_level;
	logic                         sample_valid;
	logic                         last_sample;
	logic                         load_accepted;
	logic [tpwe_pkg::ONES_W-1:0]  ones_in_byte;
	logic [tpwe_pkg::TOTAL_W-1:0] total_samples;

	modport source(output valid, sample_level, sample_valid, last_sample,
		load_accepted, ones_in_byte, total_samples, input ready);
	modport sink(input valid, sample_level, sample_valid, last_sample,
		load_accepted, ones_in_byte, total_samples, output ready);
endinterface

interface tpwe_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tpwe_pkg::REG_W-1:0]  index;
	logic [tpwe_pkg::DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/tpwe_pulse_sel.sv =====
// ----------------------------------------------------------------------------
// tpwe_pulse_sel: next pulse selection
// From the sequencer state, picks whether the next pulse is long or short
// and advances the run counters, or flags the end of the sequence.
// ----------------------------------------------------------------------------
module tpwe_pulse_sel (
	input  tpwe_pkg::seq_t   cur,
	output tpwe_pkg::pulse_t res
);

	logic                          done;
	logic                          is_long;
	tpwe_pkg::seq_t                nxt;
	logic [tpwe_pkg::POS_W-1:0]    pos;
	logic [tpwe_pkg::POS_W-1:0]    lo_off;

	assign pos    = cur.bit_index;
	assign lo_off = pos - tpwe_pkg::CSUM_LO_START;

	// Select the next pulse for the running sequence
	always_comb begin
		nxt     = cur;
		done    = 1'b0;
		is_long = 1'b0;
		unique case (cur.kind)
			tpwe_pkg::KIND_GAP: begin
				if (cur.pulses_left != '0) begin
					nxt.pulses_left = cur.pulses_left - 1'b1;
				end else begin
					done = 1'b1;
				end
			end
			tpwe_pkg::KIND_MARK: begin
				if (cur.pulses_left != '0) begin
					nxt.pulses_left = cur.pulses_left - 1'b1;
					is_long         = (cur.mark_stage != tpwe_pkg::MARK_SHORT_RUN);
				end else if (cur.mark_stage == tpwe_pkg::MARK_LONG_RUN) begin
					// enter the short run, or skip it when n is zero
					if (cur.bit_shift != '0) begin
						nxt.mark_stage  = tpwe_pkg::MARK_SHORT_RUN;
						nxt.pulses_left = cur.bit_shift - 1'b1;
					end else begin
						nxt.mark_stage  = tpwe_pkg::MARK_CLOSE;
						nxt.pulses_left = tpwe_pkg::COUNT_W'(1);
						is_long         = 1'b1;
					end
				end else if (cur.mark_stage == tpwe_pkg::MARK_SHORT_RUN) begin
					nxt.mark_stage  = tpwe_pkg::MARK_CLOSE;
					nxt.pulses_left = tpwe_pkg::COUNT_W'(1);
					is_long         = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
			tpwe_pkg::KIND_BYTE: begin
				if (pos >= tpwe_pkg::BYTE_END) begin
					done = 1'b1;
				end else begin
					nxt.bit_index = pos + 1'b1;
					if (pos < tpwe_pkg::BYTE_DATA_END) begin
						is_long = cur.bit_shift[3'd7 - pos[2:0]];
					end else begin
						is_long = 1'b1;
					end
				end
			end
			tpwe_pkg::KIND_CSUM: begin
				if (pos >= tpwe_pkg::CSUM_END) begin
					done = 1'b1;
				end else begin
					nxt.bit_index = pos + 1'b1;
					if (pos < tpwe_pkg::BYTE_DATA_END) begin
						is_long = cur.bit_shift[8 + 3'd7 - pos[2:0]];
					end else if (pos >= tpwe_pkg::CSUM_LO_START
						&& pos <= tpwe_pkg::CSUM_LO_LAST) begin
						is_long = cur.bit_shift[3'd7 - lo_off[2:0]];
					end else begin
						is_long = 1'b1;
					end
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase

		// Drop back to idle at the end of the sequence
		if (done) begin
			nxt.kind       = tpwe_pkg::KIND_IDLE;
			nxt.mark_stage = '0;
			nxt.pulse_long = 1'b0;
		end else begin
			nxt.pulse_long = is_long;
		end
	end

	assign res.done = done;
	assign res.nxt  = nxt;

endmodule

// ===== rtl/core/tape_pulse_width_encoder.sv =====
// ----------------------------------------------------------------------------
// tape_pulse_width_encoder: cassette signal sample generator
// Runs gap, tape mark, byte and checksum pulse sequences one sample per tick.
//
//   Channel  Dir  Transfer             Carries
//   req      in   valid && ready       command, repeat_count, payload
//   rsp      out  valid && ready       sample flags, ones count, sample total
//   cfg      in   valid (ready is 1)   register index, 16-bit write data
//
// Every command yields one result in the cycle after its transfer; a new
// command is taken every cycle while the result register is empty or being
// drained. The rate is set by the single state update between the command
// transfer and the result register. rsp stalls hold the result and block req.
// Reset clears the sequencer to idle, the total to zero and the registers to
// their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tape_pulse_width_encoder (
	input  logic            clk,
	input  logic            arst_n,
	tpwe_req_if.sink        req,
	tpwe_rsp_if.source      rsp,
	tpwe_cfg_if.sink        cfg
);

	// Configuration registers
	logic [tpwe_pkg::COUNT_W-1:0] long_low_q, long_high_q, short_low_q, short_high_q;
	logic                         invert_q;

	// Sequencer state
	tpwe_pkg::seq_t               seq_q;
	logic                         phase_high_q;
	logic [tpwe_pkg::COUNT_W-1:0] samples_left_q;
	logic [tpwe_pkg::TOTAL_W-1:0] total_q;

	// Result register
	logic                         out_valid_q;
	logic                         level_q, smp_valid_q, last_q, acc_q;
	logic [tpwe_pkg::ONES_W-1:0]  ones_q;

	// Next-state signals
	logic                         accept, busy, is_tick, is_load, load_ok;
	tpwe_pkg::seq_t               loaded, sel_in, seq_d;
	tpwe_pkg::pulse_t             po;
	logic                         phase_high_d;
	logic [tpwe_pkg::COUNT_W-1:0] samples_left_d, sl_dec, low_width;
	logic [tpwe_pkg::TOTAL_W-1:0] total_d;
	logic                         level_d, smp_valid_d, last_d;
	logic [tpwe_pkg::ONES_W-1:0]  ones_d;

	assign cfg.ready = 1'b1;
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign busy      = (seq_q.kind != tpwe_pkg::KIND_IDLE);
	assign is_tick   = (req.command == tpwe_pkg::CMD_TICK);
	assign is_load   = (req.command == tpwe_pkg::CMD_GAP) || (req.command == tpwe_pkg::CMD_MARK)
		|| (req.command == tpwe_pkg::CMD_BYTE) || (req.command == tpwe_pkg::CMD_CSUM);
	assign load_ok   = is_load && !busy;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_low_q   <= tpwe_pkg::COUNT_W'(1);
			long_high_q  <= tpwe_pkg::COUNT_W'(1);
			short_low_q  <= tpwe_pkg::COUNT_W'(1);
			short_high_q <= tpwe_pkg::COUNT_W'(1);
			invert_q     <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				tpwe_pkg::REG_LONG_LOW:   long_low_q   <= cfg.data;
				tpwe_pkg::REG_LONG_HIGH:  long_high_q  <= cfg.data;
				tpwe_pkg::REG_SHORT_LOW:  short_low_q  <= cfg.data;
				tpwe_pkg::REG_SHORT_HIGH: short_high_q <= cfg.data;
				tpwe_pkg::REG_INVERT:     invert_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Build the sequencer state of a fresh load
	always_comb begin
		loaded            = '0;
		loaded.kind       = tpwe_pkg::kind_t'(req.command);
		if (req.command == tpwe_pkg::CMD_GAP || req.command == tpwe_pkg::CMD_MARK) begin
			loaded.pulses_left = req.repeat_count;
			loaded.bit_shift   = req.repeat_count;
		end else if (req.command == tpwe_pkg::CMD_BYTE) begin
			loaded.bit_shift   = {8'd0, req.payload[7:0]};
		end else begin
			loaded.bit_shift   = req.payload;
		end
	end

	assign sel_in = load_ok ? loaded : seq_q;

	tpwe_pulse_sel u_pulse_sel (
		.cur (sel_in),
		.res (po)
	);

	assign low_width = po.nxt.pulse_long ? tpwe_pkg::width_of(long_low_q)
		: tpwe_pkg::width_of(short_low_q);
	assign sl_dec    = samples_left_q - tpwe_pkg::COUNT_W'(samples_left_q != '0);

	// Advance the sequencer for a tick or a load
	always_comb begin
		seq_d          = seq_q;
		phase_high_d   = phase_high_q;
		samples_left_d = samples_left_q;
		total_d        = total_q;
		level_d        = 1'b0;
		smp_valid_d    = 1'b0;
		last_d         = 1'b0;
		ones_d         = '0;
		if (is_tick && busy) begin
			level_d        = phase_high_q ^ invert_q;
			smp_valid_d    = 1'b1;
			total_d        = total_q + 1'b1;
			samples_left_d = sl_dec;
			if (sl_dec == '0) begin
				if (!phase_high_q) begin
					phase_high_d   = 1'b1;
					samples_left_d = seq_q.pulse_long ? tpwe_pkg::width_of(long_high_q)
						: tpwe_pkg::width_of(short_high_q);
				end else begin
					seq_d          = po.nxt;
					phase_high_d   = 1'b0;
					samples_left_d = po.done ? '0 : low_width;
					last_d         = po.done;
				end
			end
		end else if (load_ok) begin
			seq_d          = po.nxt;
			phase_high_d   = 1'b0;
			samples_left_d = po.done ? '0 : low_width;
			if (req.command == tpwe_pkg::CMD_BYTE) begin
				ones_d = tpwe_pkg::ones8(req.payload[7:0]);
			end
		end
	end

	// Update sequencer state on a command transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q          <= '0;
			phase_high_q   <= 1'b0;
			samples_left_q <= '0;
			total_q        <= '0;
		end else if (accept) begin
			seq_q          <= seq_d;
			phase_high_q   <= phase_high_d;
			samples_left_q <= samples_left_d;
			total_q        <= total_d;
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_q     <= level_d;
			smp_valid_q <= smp_valid_d;
			last_q      <= last_d;
			acc_q       <= load_ok;
			ones_q      <= ones_d;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.sample_level  = level_q;
	assign rsp.sample_valid  = smp_valid_q;
	assign rsp.last_sample   = last_q;
	assign rsp.load_accepted = acc_q;
	assign rsp.ones_in_byte  = ones_q;
	assign rsp.total_samples = total_q;

	// Idle sequencer holds no phase
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (!phase_high_q && samples_left_q == '0))
		else $error("idle sequencer with pending phase");

	// A running phase always has a sample left
	a_busy_phase: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (samples_left_q != '0))
		else $error("busy sequencer with empty phase");

	// The last sample of a sequence leaves the sequencer idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.last_sample) |-> !busy)
		else $error("sequencer still busy after last sample");

	// A load result never carries a sample
	a_load_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.load_accepted) |-> (!rsp.sample_valid && !rsp.last_sample))
		else $error("load result flagged as sample");

	// A stalled result blocks new commands
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("command taken while result stalled");

endmodule
